// File: hw/rtl/shared_pool_multi_stack_unit_macros.svh
// assertion macros shared by the multi stack unit
`ifndef SHARED_POOL_MULTI_STACK_UNIT_MACROS_SVH
`define SHARED_POOL_MULTI_STACK_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sps_pkg.sv
// package: widths, codes and defaults of the multi stack unit
package sps_pkg;

   localparam int DEF_NUM_STACKS = 8;
   localparam int DEF_POOL_DEPTH = 256;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int CAP_W    = 9;
   localparam int ID_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'h100;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic data_we;
      logic link_we;
   } sps_mem_ctrl_type;

endpackage

// File: hw/rtl/sps_req_if.sv
// request channel: push or pop beat toward the unit
interface sps_req_if
   import sps_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [ID_W-1:0]       stack_id;
   logic [DATA_WIDTH-1:0] push_data;

   modport source (output valid, req_type, stack_id, push_data, input ready);
   modport sink   (input valid, req_type, stack_id, push_data, output ready);
endinterface

// File: hw/rtl/sps_rsp_if.sv
// response channel: status and popped data beat from the unit
interface sps_rsp_if
   import sps_pkg::*;
#(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] pop_data;

   modport source (output valid, status, pop_data, input ready);
   modport sink   (input valid, status, pop_data, output ready);
endinterface

// File: hw/rtl/sps_entry_store.sv
// entry store: data and link memories with registered reads and write bypass
module sps_entry_store
   import sps_pkg::*;
#(
   parameter int POOL_DEPTH = DEF_POOL_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int ADDR_W     = $clog2(DEF_POOL_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sps_mem_ctrl_type      ctrl,
   input  logic [ADDR_W-1:0]     rd_data_addr,
   input  logic [ADDR_W-1:0]     rd_link_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     wr_link,
   output logic [DATA_WIDTH-1:0] rd_data,
   output logic [ADDR_W-1:0]     rd_link
);

   logic [DATA_WIDTH-1:0] data_mem [POOL_DEPTH];
   logic [ADDR_W-1:0]     link_mem [POOL_DEPTH];

   logic [DATA_WIDTH-1:0] data_q_ff;
   logic [ADDR_W-1:0]     link_q_ff;
   logic [DATA_WIDTH-1:0] byp_data_ff;
   logic [ADDR_W-1:0]     byp_link_ff;
   logic                  data_hit_ff;
   logic                  link_hit_ff;

   always_ff @(posedge clock) begin
      if (ctrl.data_we) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (ctrl.link_we) begin
         link_mem[wr_addr] <= wr_link;
      end
      if (ctrl.rd_en) begin
         data_q_ff   <= data_mem[rd_data_addr];
         link_q_ff   <= link_mem[rd_link_addr];
         byp_data_ff <= wr_data;
         byp_link_ff <= wr_link;
      end
   end

   // a read that lands on the entry written in the same cycle takes the new value
   always_ff @(posedge clock) begin
      if (reset) begin
         data_hit_ff <= 1'b0;
         link_hit_ff <= 1'b0;
      end else if (ctrl.rd_en) begin
         data_hit_ff <= ctrl.data_we && (wr_addr == rd_data_addr);
         link_hit_ff <= ctrl.link_we && (wr_addr == rd_link_addr);
      end
   end

   assign rd_data = data_hit_ff ? byp_data_ff : data_q_ff;
   assign rd_link = link_hit_ff ? byp_link_ff : link_q_ff;

endmodule

// File: hw/rtl/sps_engine.sv
// request stage and stack bookkeeping: tops, depths, free list, usage
`include "shared_pool_multi_stack_unit_macros.svh"

module sps_engine
   import sps_pkg::*;
#(
   parameter int NUM_STACKS = DEF_NUM_STACKS,
   parameter int POOL_DEPTH = DEF_POOL_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int ADDR_W     = $clog2(DEF_POOL_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  commit,
   input  logic                  in_req_type,
   input  logic [ID_W-1:0]       in_stack_id,
   input  logic [DATA_WIDTH-1:0] in_push_data,
   input  logic                  csr_we,
   input  logic [CAP_W-1:0]      csr_data,
   input  logic [DATA_WIDTH-1:0] rd_data,
   input  logic [ADDR_W-1:0]     rd_link,
   output sps_mem_ctrl_type      mem_ctrl,
   output logic [ADDR_W-1:0]     rd_data_addr,
   output logic [ADDR_W-1:0]     rd_link_addr,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [DATA_WIDTH-1:0] wr_data,
   output logic [ADDR_W-1:0]     wr_link,
   output logic [STATUS_W-1:0]   status,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int IDX_W = (SID_W > ID_W) ? SID_W : ID_W;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // stack state
   logic [ADDR_W-1:0] top_ff   [NUM_STACKS];
   logic [CNT_W-1:0]  depth_ff [NUM_STACKS];
   logic [ADDR_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CAP_W-1:0]  cap_ff;

   // request stage, with the addressed stack's top and depth captured on accept
   logic                  a_pop_ff;
   logic [SID_W-1:0]      a_sid_ff;
   logic                  a_id_ok_ff;
   logic [DATA_WIDTH-1:0] a_word_ff;
   logic [ADDR_W-1:0]     a_top_ff;
   logic [CNT_W-1:0]      a_depth_ff;

   logic              free_valid;
   logic              limit_hit;
   logic              push_ok;
   logic              pop_ok;
   logic              change;
   logic [ADDR_W-1:0] push_slot;
   logic [ADDR_W-1:0] top_in;
   logic [CNT_W-1:0]  depth_in;

   logic [IDX_W-1:0]  n_wide;
   logic              n_ok;
   logic [SID_W-1:0]  n_sid;
   logic              fwd;
   logic [ADDR_W-1:0] n_top;
   logic [CNT_W-1:0]  n_depth;

   assign free_valid = fresh_ff > used_ff;
   assign limit_hit  = (CMP_W'(used_ff) >= CMP_W'(cap_ff))
                    || (used_ff >= CNT_W'(POOL_DEPTH));
   assign push_ok    = (a_pop_ff == REQ_PUSH) && a_id_ok_ff && !limit_hit;
   assign pop_ok     = (a_pop_ff == REQ_POP) && a_id_ok_ff && (a_depth_ff != '0);
   assign change     = commit && (push_ok || pop_ok);
   assign push_slot  = free_valid ? free_head_ff : fresh_ff[ADDR_W-1:0];
   assign top_in     = push_ok ? push_slot : rd_link;
   assign depth_in   = push_ok ? (a_depth_ff + 1'b1) : (a_depth_ff - 1'b1);

   always_comb begin
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      used_in      = used_ff;
      if (commit && push_ok) begin
         used_in = used_ff + 1'b1;
         if (free_valid) begin
            free_head_in = rd_link;
         end else begin
            fresh_in = fresh_ff + 1'b1;
         end
      end else if (commit && pop_ok) begin
         used_in      = used_ff - 1'b1;
         free_head_in = a_top_ff;
      end
   end

   // next request: its top comes forwarded when the current one changes that stack
   assign n_wide  = IDX_W'(in_stack_id);
   assign n_ok    = {1'b0, n_wide} < (IDX_W + 1)'(NUM_STACKS);
   assign n_sid   = n_ok ? n_wide[SID_W-1:0] : '0;
   assign fwd     = change && (a_sid_ff == n_sid);
   assign n_top   = fwd ? top_in : top_ff[n_sid];
   assign n_depth = fwd ? depth_in : depth_ff[n_sid];

   assign rd_data_addr = n_top;
   assign rd_link_addr = (in_req_type == REQ_POP) ? n_top : free_head_in;

   assign mem_ctrl.rd_en   = accept;
   assign mem_ctrl.data_we = commit && push_ok;
   assign mem_ctrl.link_we = change;
   assign wr_addr = push_ok ? push_slot : a_top_ff;
   assign wr_data = a_word_ff;
   assign wr_link = push_ok ? a_top_ff : free_head_ff;

   always_comb begin
      status   = ST_OK;
      pop_data = '0;
      if (a_pop_ff == REQ_PUSH) begin
         if (!push_ok) begin
            status = ST_OVERFLOW;
         end
      end else if (pop_ok) begin
         pop_data = rd_data;
      end else begin
         status = ST_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pop_ff   <= in_req_type;
         a_sid_ff   <= n_sid;
         a_id_ok_ff <= n_ok;
         a_word_ff  <= in_push_data;
         a_top_ff   <= n_top;
         a_depth_ff <= n_depth;
      end
      if (change) begin
         top_ff[a_sid_ff] <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            depth_ff[i] <= '0;
         end
         free_head_ff <= '0;
         fresh_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
      end else begin
         if (change) begin
            depth_ff[a_sid_ff] <= depth_in;
         end
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         used_ff      <= used_in;
         if (csr_we) begin
            cap_ff <= csr_data;
         end
      end
   end

   `SPS_ASSERT_NOW(a_fresh_covers_used, clock, reset, 1'b1, fresh_ff >= used_ff, "entries in use exceed entries ever taken")
   `SPS_ASSERT_NOW(a_used_in_pool, clock, reset, 1'b1, used_ff <= CNT_W'(POOL_DEPTH), "usage count beyond pool size")
   `SPS_ASSERT_NEXT(a_push_counts, clock, reset, commit && push_ok, used_ff == $past(used_ff) + 1'b1, "successful push did not raise usage")

endmodule

// File: hw/rtl/shared_pool_multi_stack_unit.sv
// Multiple LIFO stacks over one shared pool of linked entries.
// Each accepted request beat yields one result beat from the response register.
// Throughput: one request per cycle unless stalled; the request stage does one
// read of the data and link memories and forwards the stack top to the next
// request. Reset is synchronous and takes effect at once: all stacks empty, no
// freed entries, capacity limit 256; the entry memories need no clearing pass.
`include "shared_pool_multi_stack_unit_macros.svh"

module shared_pool_multi_stack_unit
   import sps_pkg::*;
#(
   parameter int NUM_STACKS = DEF_NUM_STACKS,
   parameter int POOL_DEPTH = DEF_POOL_DEPTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   sps_req_if.sink          req_chan,
   sps_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(POOL_DEPTH);

   sps_mem_ctrl_type      mem_ctrl;
   logic [ADDR_W-1:0]     rd_data_addr;
   logic [ADDR_W-1:0]     rd_link_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [ADDR_W-1:0]     wr_link;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [ADDR_W-1:0]     rd_link;
   logic [STATUS_W-1:0]   status;
   logic [DATA_WIDTH-1:0] pop_data;

   logic                  a_valid_ff;
   logic                  accept;
   logic                  commit;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;

   // the request stage retires whenever the response register is free
   assign commit         = a_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || commit;
   assign accept         = req_chan.valid && req_chan.ready;

   sps_engine #(
      .NUM_STACKS (NUM_STACKS),
      .POOL_DEPTH (POOL_DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .commit       (commit),
      .in_req_type  (req_chan.req_type),
      .in_stack_id  (req_chan.stack_id),
      .in_push_data (req_chan.push_data),
      .csr_we       (csr_we),
      .csr_data     (csr_data),
      .rd_data      (rd_data),
      .rd_link      (rd_link),
      .mem_ctrl     (mem_ctrl),
      .rd_data_addr (rd_data_addr),
      .rd_link_addr (rd_link_addr),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .wr_link      (wr_link),
      .status       (status),
      .pop_data     (pop_data)
   );

   sps_entry_store #(
      .POOL_DEPTH (POOL_DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (mem_ctrl),
      .rd_data_addr (rd_data_addr),
      .rd_link_addr (rd_link_addr),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .wr_link      (wr_link),
      .rd_data      (rd_data),
      .rd_link      (rd_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (commit) begin
            a_valid_ff <= 1'b0;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status;
         rsp_data_ff   <= pop_data;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.pop_data = rsp_data_ff;

   `SPS_ASSERT_NEXT(a_commit_shows_beat, clock, reset, commit, rsp_valid_ff, "retired request left no response beat")
   `SPS_ASSERT_NOW(a_fail_has_no_data, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_data_ff == '0, "failed request returned data")
   `SPS_ASSERT_NEXT(a_stall_keeps_stage, clock, reset, a_valid_ff && rsp_valid_ff && !rsp_chan.ready, a_valid_ff, "request lost while response stalled")

endmodule

// File: tb/shared_pool_multi_stack_unit_tb.sv
// testbench for the shared pool multi stack unit: directed and random push/pop traffic
`timescale 1ns / 100ps

module shared_pool_multi_stack_unit_tb
   import sps_pkg::*;
();

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [DEF_DATA_WIDTH-1:0] pop_data;
   } stack_reply_type;

   class stack_pool_tracker_type;
      localparam int NSTK = DEF_NUM_STACKS;
      localparam int POOL = DEF_POOL_DEPTH;

      logic [DEF_DATA_WIDTH-1:0] slot_word [POOL];
      logic [7:0]                slot_next [POOL];
      logic [7:0]                top_slot  [NSTK];
      int unsigned               depth_of  [NSTK];
      logic [7:0]                recycled_head;
      int unsigned               fresh_taken;
      int unsigned               in_use;
      int unsigned               cap_limit;
      stack_reply_type           expected_replies[$];

      int errors;
      int n_push_ok, n_overflow, n_pop_ok, n_underflow;
      int unsigned peak_in_use;

      function new();
         foreach (depth_of[i]) begin
            depth_of[i] = 0;
            top_slot[i] = '0;
         end
         recycled_head = '0;
         fresh_taken = 0;
         in_use = 0;
         cap_limit = CAP_RESET;
         errors = 0;
         n_push_ok = 0;
         n_overflow = 0;
         n_pop_ok = 0;
         n_underflow = 0;
         peak_in_use = 0;
      endfunction

      function void set_limit(logic [CAP_W-1:0] v);
         cap_limit = v;
      endfunction

      function int outstanding();
         return expected_replies.size();
      endfunction

      // work out the reply to one request and advance the pool state
      function stack_reply_type predict_reply(logic op, logic [ID_W-1:0] id,
                                              logic [DEF_DATA_WIDTH-1:0] word);
         stack_reply_type r;
         int unsigned lim;
         logic [7:0] slot;
         r.status = ST_OK;
         r.pop_data = '0;
         lim = (cap_limit > POOL) ? POOL : cap_limit;
         if (op == REQ_PUSH) begin
            if (int'(id) >= NSTK || in_use >= lim) begin
               r.status = ST_OVERFLOW;
               n_overflow++;
            end else begin
               // freed entries are reused before untouched ones
               if (fresh_taken > in_use) begin
                  slot = recycled_head;
                  recycled_head = slot_next[slot];
               end else begin
                  slot = fresh_taken[7:0];
                  fresh_taken++;
               end
               slot_word[slot] = word;
               slot_next[slot] = top_slot[id];
               top_slot[id] = slot;
               depth_of[id]++;
               in_use++;
               n_push_ok++;
               if (in_use > peak_in_use) peak_in_use = in_use;
            end
         end else begin
            if (int'(id) >= NSTK || depth_of[id] == 0) begin
               r.status = ST_UNDERFLOW;
               n_underflow++;
            end else begin
               slot = top_slot[id];
               r.pop_data = slot_word[slot];
               top_slot[id] = slot_next[slot];
               slot_next[slot] = recycled_head;
               recycled_head = slot;
               depth_of[id]--;
               in_use--;
               n_pop_ok++;
            end
         end
         return r;
      endfunction

      function void note_request(logic op, logic [ID_W-1:0] id,
                                 logic [DEF_DATA_WIDTH-1:0] word);
         expected_replies.push_back(predict_reply(op, id, word));
      endfunction

      function void check_result(logic [STATUS_W-1:0] status,
                                 logic [DEF_DATA_WIDTH-1:0] data);
         stack_reply_type want;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: reply beat with nothing pending, got status %0d data %h",
                     $time, status, data);
            return;
         end
         want = expected_replies.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
         end
         if (data !== want.pop_data) begin
            errors++;
            $display("%0t: pop_data mismatch, expected %h, got %h", $time, want.pop_data, data);
         end
      endfunction
   endclass

   localparam int DW = DEF_DATA_WIDTH;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_data;

   int req_idle_pct = 37;
   int rsp_idle_pct = 37;
   int hold_request = 0;
   int items_sent = 0;

   stack_pool_tracker_type tracker = new();

   sps_req_if #(.DATA_WIDTH(DW)) req_if ();
   sps_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

   shared_pool_multi_stack_unit #(
      .NUM_STACKS(DEF_NUM_STACKS),
      .POOL_DEPTH(DEF_POOL_DEPTH),
      .DATA_WIDTH(DW)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_we   (csr_we),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // reply checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            tracker.check_result(rsp_if.status, rsp_if.pop_data);
         if (req_if.valid && req_if.ready)
            tracker.note_request(req_if.req_type, req_if.stack_id, req_if.push_data);
      end
   end

   task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
                            input logic [DW-1:0] word);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= op;
      req_if.stack_id  <= id;
      req_if.push_data <= word;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait for every pending reply, then a little slack
   task automatic settle();
      req_if.valid <= 1'b0;
      // let the monitor log the last accepted beat first
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CAP_W-1:0] v);
      csr_data <= v;
      csr_we   <= 1'b1;
      @(posedge clock);
      csr_we   <= 1'b0;
      tracker.set_limit(v);
   endtask

   task automatic run_mix(input int count, input int push_pct, input int id_hi);
      logic          op;
      logic [DW-1:0] word;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
         case ($urandom_range(0, 15))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
         endcase
         send_beat(op, ID_W'($urandom_range(0, id_hi)), word);
      end
   endtask

   initial begin
      #(4_000_000);
      $display("timeout with %0d replies still pending", tracker.outstanding());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_data         <= '0;
      req_if.valid     <= 1'b0;
      req_if.req_type  <= REQ_PUSH;
      req_if.stack_id  <= '0;
      req_if.push_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pops, extreme data and stacks, free list reuse
      send_beat(REQ_POP,  3'd0, 32'h1234_5678);
      send_beat(REQ_POP,  3'd7, 32'hFFFF_FFFF);
      send_beat(REQ_PUSH, 3'd0, 32'h0000_0000);
      send_beat(REQ_PUSH, 3'd7, 32'hFFFF_FFFF);
      send_beat(REQ_PUSH, 3'd3, 32'hA5A5_A5A5);
      send_beat(REQ_PUSH, 3'd0, 32'h5A5A_5A5A);
      send_beat(REQ_POP,  3'd7, 32'h0000_0000);
      send_beat(REQ_POP,  3'd7, 32'h8000_0001);
      send_beat(REQ_POP,  3'd0, 32'h0F0F_0F0F);
      send_beat(REQ_PUSH, 3'd5, 32'h1234_5678);
      send_beat(REQ_POP,  3'd0, 32'hF0F0_F0F0);
      send_beat(REQ_POP,  3'd3, 32'h0000_0000);
      send_beat(REQ_POP,  3'd5, 32'hFFFF_FFFF);
      settle();

      // zero limit: every push overflows
      write_limit(9'd0);
      send_beat(REQ_PUSH, 3'd1, 32'hCAFE_F00D);
      send_beat(REQ_POP,  3'd1, 32'h0000_0001);
      settle();

      // limit of one entry
      write_limit(9'd1);
      send_beat(REQ_PUSH, 3'd2, 32'hDEAD_BEEF);
      send_beat(REQ_PUSH, 3'd4, 32'h7FFF_FFFF);
      send_beat(REQ_POP,  3'd4, 32'h0000_0000);
      send_beat(REQ_POP,  3'd2, 32'h0000_0000);
      send_beat(REQ_PUSH, 3'd6, 32'h8000_0000);
      send_beat(REQ_POP,  3'd6, 32'hFFFF_FFFF);
      settle();

      // balanced traffic with a long receiver hold-off in the middle
      write_limit(9'd256);
      run_mix(40, 60, 7);
      hold_request = 60;
      req_idle_pct = 0;
      run_mix(30, 60, 7);
      req_idle_pct = 37;
      settle();
      run_mix(50, 60, 7);
      settle();

      // limit above the pool: fill every entry, then overflow on a full pool
      write_limit(9'd511);
      run_mix(280, 95, 7);
      settle();

      // drain mostly, with no idling on either side
      write_limit(9'd200);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_mix(230, 10, 7);
      settle();
      req_idle_pct = 37;
      rsp_idle_pct = 37;

      // tiny limit on a couple of stacks
      write_limit(9'd3);
      run_mix(80, 50, 1);
      settle();

      // just above the pool size
      write_limit(9'd257);
      run_mix(60, 50, 7);
      req_if.valid <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < 1000 && tracker.outstanding() != 0; k++) @(posedge clock);
      repeat (5) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         tracker.errors++;
         $display("%0t: %0d replies never arrived", $time, tracker.outstanding());
      end

      $display("run: %0d requests; %0d pushes stored, %0d overflows, %0d pops, %0d underflows",
               items_sent, tracker.n_push_ok, tracker.n_overflow, tracker.n_pop_ok,
               tracker.n_underflow);
      $display("limits 0, 1, 3, 200, 256, 257, 511; peak entries held %0d of %0d",
               tracker.peak_in_use, DEF_POOL_DEPTH);
      if (tracker.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
